// File: rtl/xrg_pkg.sv
// Types and constants shared by the xoshiro256++ generator modules.
`default_nettype none
package xrg_pkg;

    typedef enum logic [2:0] {
        REQ_RAW      = 3'd0,
        REQ_FRACTION = 3'd1,
        REQ_BOUNDED  = 3'd2,
        REQ_RESEED   = 3'd3,
        REQ_LOAD     = 3'd4,
        REQ_READ     = 3'd5,
        REQ_BAD6     = 3'd6,
        REQ_BAD7     = 3'd7
    } req_t;

    // One decoded command as it sits in the queue.
    typedef struct packed {
        req_t        kind;
        logic [60:0] bound;
        logic [63:0] seed_value;
        logic [1:0]  word_index;
        logic [63:0] word_value;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_MIX_A,
        ST_MIX_B,
        ST_MIX_C,
        ST_MUL,
        ST_OUT
    } state_t;

    localparam logic [63:0] RESET_W0 = 64'h31a0da5e61a2e459;
    localparam logic [63:0] RESET_W1 = 64'he68b3048ea5f11a5;
    localparam logic [63:0] RESET_W2 = 64'hbd0fbca6c09e762a;
    localparam logic [63:0] RESET_W3 = 64'h1ea62c6af476c5e9;
    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_M1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_M2   = 64'h94d049bb133111eb;
    localparam logic [60:0] DRAW_SPAN = 61'h1000000000000000;
    localparam int          DRAW_BITS = 60;

endpackage
`default_nettype wire

// File: rtl/xrg_queue.sv
// Small command queue between request front end and execution back end.
`default_nettype none
module xrg_queue #(
    parameter int DEPTH_LOG2 = 1
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire xrg_pkg::cmd_t  wr_cmd,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output xrg_pkg::cmd_t       rd_cmd
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    xrg_pkg::cmd_t           mem [DEPTH];
    logic [DEPTH_LOG2-1:0]   wptr_reg, rptr_reg;
    logic [DEPTH_LOG2:0]     count_reg;

    assign wr_ready = (count_reg != (DEPTH_LOG2+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) begin
            mem[wptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (wr_valid && wr_ready) wptr_reg <= wptr_reg + 1'b1;
            if (rd_valid && rd_ready) rptr_reg <= rptr_reg + 1'b1;
            case ({wr_valid && wr_ready, rd_valid && rd_ready})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/xrg_front.sv
// Request front end: unpacks the input transfer and classifies the request.
`default_nettype none
module xrg_front (
    input  wire logic [191:0] s_tdata,
    input  wire logic [2:0]   s_tuser,
    output xrg_pkg::cmd_t     cmd
);
    always_comb begin
        cmd.kind       = xrg_pkg::req_t'(s_tuser);
        cmd.bound      = s_tdata[60:0];
        cmd.seed_value = s_tdata[124:61];
        cmd.word_index = s_tdata[126:125];
        cmd.word_value = s_tdata[190:127];
        // the bound field is zeroed for all but bounded requests so no stale bits drive the divider
        if (cmd.kind != xrg_pkg::REQ_BOUNDED) cmd.bound = '0;
    end
endmodule
`default_nettype wire

// File: rtl/xrg_back.sv
// Execution back end: generator state, draws, modulo unit, splitmix reseed.
`default_nettype none
module xrg_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire xrg_pkg::cmd_t cmd,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata
);
    xrg_pkg::state_t state_reg, state_next;
    logic [63:0] w_reg [4];
    logic [63:0] out_reg;
    logic        out_valid_reg;
    xrg_pkg::cmd_t cur_reg;
    // restoring divider
    logic [59:0] quo_reg;       // dividend bits, shifted out msb first
    logic [60:0] rem_reg;
    logic [59:0] draw_reg;
    logic [5:0]  bit_reg;
    // splitmix
    logic [63:0] acc_reg, z_reg;
    logic [1:0]  mix_idx_reg;
    // 64-bit product low half built from three 32x32 partial products
    logic [63:0] mul_a_reg;
    logic        mul_sel_reg;   // 0: first mix constant, 1: second
    logic [1:0]  mul_step_reg;

    logic [63:0] gen_out;
    logic [63:0] nw0, nw1, nw2, nw3, t17, sum03;
    logic [61:0] rem_shift;
    logic [60:0] limit;
    logic [63:0] acc_inc;
    logic [63:0] mul_b;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;

    always_comb begin
        sum03 = w_reg[0] + w_reg[3];
        gen_out = {sum03[40:0], sum03[63:41]} + w_reg[0];
        t17 = {w_reg[1][46:0], 17'd0};
        nw2 = w_reg[2] ^ w_reg[0];
        nw3 = w_reg[3] ^ w_reg[1];
        nw1 = w_reg[1] ^ nw2;
        nw0 = w_reg[0] ^ nw3;
        nw2 = nw2 ^ t17;
        nw3 = {nw3[18:0], nw3[63:19]};
        rem_shift = {rem_reg, quo_reg[59]};
        limit = (cur_reg.bound >= xrg_pkg::DRAW_SPAN) ? '0
              : xrg_pkg::DRAW_SPAN - cur_reg.bound;
        acc_inc = acc_reg + xrg_pkg::GOLDEN;
        mul_b = mul_sel_reg ? xrg_pkg::MIX_M2 : xrg_pkg::MIX_M1;
        case (mul_step_reg)
            2'd0: begin
                mul_x = mul_a_reg[31:0];
                mul_y = mul_b[31:0];
            end
            2'd1: begin
                mul_x = mul_a_reg[31:0];
                mul_y = mul_b[63:32];
            end
            default: begin
                mul_x = mul_a_reg[63:32];
                mul_y = mul_b[31:0];
            end
        endcase
        mul_p = {32'd0, mul_x} * {32'd0, mul_y};
    end

    assign cmd_ready = (state_reg == xrg_pkg::ST_IDLE) && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            xrg_pkg::ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    if (cmd.kind == xrg_pkg::REQ_BOUNDED && cmd.bound != '0)
                        state_next = xrg_pkg::ST_DIVIDE;
                    else if (cmd.kind == xrg_pkg::REQ_RESEED)
                        state_next = xrg_pkg::ST_MIX_A;
                end
            end
            xrg_pkg::ST_DIVIDE: if (bit_reg == 6'd0) state_next = xrg_pkg::ST_CHECK;
            xrg_pkg::ST_CHECK: begin
                if (({1'b0, draw_reg} - rem_reg) <= limit) state_next = xrg_pkg::ST_IDLE;
                else state_next = xrg_pkg::ST_DIVIDE;
            end
            xrg_pkg::ST_MIX_A: state_next = xrg_pkg::ST_MUL;
            xrg_pkg::ST_MUL: begin
                if (mul_step_reg == 2'd2)
                    state_next = mul_sel_reg ? xrg_pkg::ST_MIX_C : xrg_pkg::ST_MIX_B;
            end
            xrg_pkg::ST_MIX_B: state_next = xrg_pkg::ST_MUL;
            xrg_pkg::ST_MIX_C: state_next = (mix_idx_reg == 2'd3) ? xrg_pkg::ST_IDLE
                                                                   : xrg_pkg::ST_MIX_A;
            default: state_next = xrg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= xrg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            w_reg[0] <= xrg_pkg::RESET_W0;
            w_reg[1] <= xrg_pkg::RESET_W1;
            w_reg[2] <= xrg_pkg::RESET_W2;
            w_reg[3] <= xrg_pkg::RESET_W3;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                xrg_pkg::ST_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        cur_reg <= cmd;
                        case (cmd.kind)
                            xrg_pkg::REQ_RAW, xrg_pkg::REQ_FRACTION: begin
                                w_reg[0] <= nw0; w_reg[1] <= nw1;
                                w_reg[2] <= nw2; w_reg[3] <= nw3;
                                out_reg <= (cmd.kind == xrg_pkg::REQ_RAW) ? gen_out
                                         : {11'd0, gen_out[63:11]};
                                out_valid_reg <= 1'b1;
                            end
                            xrg_pkg::REQ_BOUNDED: begin
                                w_reg[0] <= nw0; w_reg[1] <= nw1;
                                w_reg[2] <= nw2; w_reg[3] <= nw3;
                                draw_reg <= gen_out[63:4];
                                quo_reg  <= gen_out[63:4];
                                rem_reg  <= '0;
                                bit_reg  <= 6'(xrg_pkg::DRAW_BITS - 1);
                                if (cmd.bound == '0) begin
                                    out_reg <= '0;
                                    out_valid_reg <= 1'b1;
                                end
                            end
                            xrg_pkg::REQ_RESEED: begin
                                acc_reg <= cmd.seed_value;
                                mix_idx_reg <= 2'd0;
                            end
                            xrg_pkg::REQ_LOAD: begin
                                w_reg[cmd.word_index] <= cmd.word_value;
                                out_reg <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            xrg_pkg::REQ_READ: begin
                                out_reg <= w_reg[cmd.word_index];
                                out_valid_reg <= 1'b1;
                            end
                            default: begin
                                out_reg <= '0;
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                xrg_pkg::ST_DIVIDE: begin
                    quo_reg <= {quo_reg[58:0], 1'b0};
                    if (rem_shift >= {1'b0, cur_reg.bound})
                        rem_reg <= 61'(rem_shift - {1'b0, cur_reg.bound});
                    else
                        rem_reg <= rem_shift[60:0];
                    bit_reg <= bit_reg - 1'b1;
                end
                xrg_pkg::ST_CHECK: begin
                    if (({1'b0, draw_reg} - rem_reg) <= limit) begin
                        out_reg <= {3'd0, rem_reg};
                        out_valid_reg <= 1'b1;
                    end else begin
                        w_reg[0] <= nw0; w_reg[1] <= nw1;
                        w_reg[2] <= nw2; w_reg[3] <= nw3;
                        draw_reg <= gen_out[63:4];
                        quo_reg  <= gen_out[63:4];
                        rem_reg  <= '0;
                        bit_reg  <= 6'(xrg_pkg::DRAW_BITS - 1);
                    end
                end
                xrg_pkg::ST_MIX_A: begin
                    acc_reg      <= acc_inc;
                    mul_a_reg    <= acc_inc ^ {30'd0, acc_inc[63:30]};
                    mul_sel_reg  <= 1'b0;
                    mul_step_reg <= 2'd0;
                end
                xrg_pkg::ST_MUL: begin
                    // low x low, then the two cross terms into the upper half
                    case (mul_step_reg)
                        2'd0:    z_reg <= mul_p;
                        default: z_reg[63:32] <= z_reg[63:32] + mul_p[31:0];
                    endcase
                    mul_step_reg <= mul_step_reg + 1'b1;
                end
                xrg_pkg::ST_MIX_B: begin
                    mul_a_reg    <= z_reg ^ {27'd0, z_reg[63:27]};
                    mul_sel_reg  <= 1'b1;
                    mul_step_reg <= 2'd0;
                end
                xrg_pkg::ST_MIX_C: begin
                    w_reg[mix_idx_reg] <= z_reg ^ {31'd0, z_reg[63:31]};
                    mix_idx_reg <= mix_idx_reg + 1'b1;
                    if (mix_idx_reg == 2'd3) begin
                        out_reg <= '0;
                        out_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/xoshiro256pp_random_generator.sv
// Top level of the xoshiro256++ request-serving random generator.
//
// Channel | Direction | tdata                                   | tuser
// s_      | in        | bound[60:0] seed_value[124:61]          | req_type[2:0]
//         |           | word_index[126:125] word_value[190:127] |
// m_      | out       | value[63:0]                             | -
//
// Raw, fraction, load, read and unknown requests are answered from the idle state.
// Bounded draw: draw, restoring divider over the 60-bit draw, then check; each
// rejected draw is redrawn and goes through the divider again. Reseed: accept,
// then four splitmix rounds of mix A, multiply, mix B, multiply, mix C; each
// 64-bit multiply sums three 32x32 partial products. Reset loads the fixed state
// words. The back end takes no new command while a result waits on m_tready; a
// two-entry queue lets input transfers land meanwhile and while the back end works.
`default_nettype none
module xoshiro256pp_random_generator #(
    parameter int QUEUE_DEPTH_LOG2 = 1
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,   // bound, seed_value, word_index, word_value
    input  wire logic [2:0]   s_tuser,   // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata    // value
);
    xrg_pkg::cmd_t in_cmd, q_cmd;
    logic          q_valid, q_ready;

    xrg_front u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (in_cmd)
    );

    xrg_queue #(.DEPTH_LOG2(QUEUE_DEPTH_LOG2)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_cmd   (in_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    xrg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the xoshiro256++ request-serving random generator.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    // Scoreboard: keeps its own copy of the four generator words, predicts the
    // value returned for every accepted request and checks results in order.
    class rng_scoreboard;
        logic [63:0] words [4];
        logic [63:0] pending_values [$];
        int mismatches;
        int failures;

        function new();
            words[0] = xrg_pkg::RESET_W0;
            words[1] = xrg_pkg::RESET_W1;
            words[2] = xrg_pkg::RESET_W2;
            words[3] = xrg_pkg::RESET_W3;
            mismatches = 0;
            failures = 0;
        endfunction

        function logic [63:0] rotl(logic [63:0] x, int k);
            return (x << k) | (x >> (64 - k));
        endfunction

        function logic [63:0] step_generator();
            logic [63:0] out_word, t;
            out_word = rotl(words[0] + words[3], 23) + words[0];
            t = words[1] << 17;
            words[2] ^= words[0];
            words[3] ^= words[1];
            words[1] ^= words[2];
            words[0] ^= words[3];
            words[2] ^= t;
            words[3] = rotl(words[3], 45);
            return out_word;
        endfunction

        function logic [63:0] splitmix(ref logic [63:0] acc);
            logic [63:0] z;
            acc += xrg_pkg::GOLDEN;
            z = acc;
            z = (z ^ (z >> 30)) * xrg_pkg::MIX_M1;
            z = (z ^ (z >> 27)) * xrg_pkg::MIX_M2;
            return z ^ (z >> 31);
        endfunction

        // Rejection loop: redraw while the 60-bit value lands in the biased tail.
        function logic [63:0] draw_below(logic [60:0] bnd);
            logic [63:0] limit, r, v, b;
            b = {3'b0, bnd};
            limit = (b >= {3'b0, xrg_pkg::DRAW_SPAN}) ? 64'd0
                  : {3'b0, xrg_pkg::DRAW_SPAN} - b;
            forever begin
                r = step_generator() >> 4;
                if (b == 0) return 64'd0;
                v = r % b;
                if (r - v <= limit) return v;
            end
        endfunction

        function void note_request(xrg_pkg::req_t kind, logic [60:0] bnd,
                                   logic [63:0] seed, logic [1:0] idx,
                                   logic [63:0] wval);
            logic [63:0] res, acc;
            res = 64'd0;
            case (kind)
                xrg_pkg::REQ_RAW:      res = step_generator();
                xrg_pkg::REQ_FRACTION: res = step_generator() >> 11;
                xrg_pkg::REQ_BOUNDED:  res = draw_below(bnd);
                xrg_pkg::REQ_RESEED: begin
                    acc = seed;
                    for (int i = 0; i < 4; i++) words[i] = splitmix(acc);
                end
                xrg_pkg::REQ_LOAD:     words[idx] = wval;
                xrg_pkg::REQ_READ:     res = words[idx];
                default:               res = 64'd0;
            endcase
            pending_values.push_back(res);
        endfunction

        function void check_value(logic [63:0] got);
            logic [63:0] want;
            if (pending_values.size() == 0) begin
                failures++;
                if (mismatches++ < 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_values.pop_front();
            if (got !== want) begin
                failures++;
                if (mismatches++ < 10) $display("value mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;

    rng_scoreboard sb;
    bit calm;        // no idling on either side
    bit hold_off;    // receiver held off for a long stretch
    bit sending_done;

    xoshiro256pp_random_generator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard limit well beyond the slowest plausible run.
    initial begin
        #400ms;
        $display("FAIL");
        $finish;
    end

    // Offer one request and hold it until the transfer happens. tvalid stays
    // high on return so back-to-back requests in calm stretches see no gap.
    task automatic send_request(xrg_pkg::req_t kind, logic [60:0] bnd, logic [63:0] seed,
                                logic [1:0] idx, logic [63:0] wval);
        while (!calm && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, wval, idx, seed, bnd};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, bnd, seed, idx, wval);
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_values.size() != 0) @(negedge aclk);
    endtask

    // Mostly small bounds keep rejection rare; a few sit near or above 2^60.
    function automatic logic [60:0] pick_bound();
        case ($urandom_range(5))
            0: return 61'($urandom_range(16, 1));
            1: return 61'({$urandom, $urandom}) >> $urandom_range(60, 1);
            2: return xrg_pkg::DRAW_SPAN - 61'($urandom_range(3));
            3: return 61'({$urandom, $urandom});
            default: return 61'($urandom) + 61'd1;
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off driven by the stimulus.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready <= !hold_off && (calm || $urandom_range(99) >= 35);
        end
    end

    // Results are sampled at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_value(m_tdata);
    end

    initial begin
        logic [63:0] mask;
        xrg_pkg::req_t kind;
        sb = new();
        calm = 1'b0;
        hold_off = 1'b0;
        sending_done = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = xrg_pkg::REQ_RAW;
        aresetn  = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset state readback, every request kind, field extremes.
        for (int i = 0; i < 4; i++) send_request(xrg_pkg::REQ_READ, '0, '0, 2'(i), '0);
        send_request(xrg_pkg::REQ_RAW, '0, '0, '0, '0);
        send_request(xrg_pkg::REQ_FRACTION, '0, '0, '0, '0);
        send_request(xrg_pkg::REQ_BOUNDED, 61'd1, '0, '0, '0);
        send_request(xrg_pkg::REQ_BOUNDED, 61'd0, '0, '0, '0);          // zero bound
        send_request(xrg_pkg::REQ_BOUNDED, xrg_pkg::DRAW_SPAN, '0, '0, '0); // full span
        send_request(xrg_pkg::REQ_BOUNDED, {61{1'b1}}, '0, '0, '0);     // above span
        send_request(xrg_pkg::REQ_BOUNDED, (xrg_pkg::DRAW_SPAN >> 1) + 61'd1,
                     '0, '0, '0);                                        // heavy rejection
        send_request(xrg_pkg::REQ_RESEED, '0, 64'd0, '0, '0);
        send_request(xrg_pkg::REQ_RESEED, '0, {64{1'b1}}, '0, '0);
        send_request(xrg_pkg::REQ_LOAD, '0, '0, 2'd3, {64{1'b1}});
        send_request(xrg_pkg::REQ_LOAD, '0, '0, 2'd0, 64'd0);
        send_request(xrg_pkg::REQ_READ, '0, '0, 2'd3, '0);
        send_request(xrg_pkg::REQ_BAD6, {61{1'b1}}, {64{1'b1}}, 2'd3, {64{1'b1}});
        send_request(xrg_pkg::REQ_BAD7, '0, '0, '0, '0);
        send_request(xrg_pkg::REQ_RAW, '0, '0, '0, '0);

        // Pause until all results have come back.
        stop_sending();
        wait_drained();

        // Long receiver hold-off while requests keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_request(xrg_pkg::REQ_RAW, '0, '0, '0, '0);
        join

        for (int n = 0; n < 1300; n++) begin
            calm = (n >= 500 && n < 650);
            mask = {$urandom, $urandom};
            case ($urandom_range(99)) inside
                [0:29]:  kind = xrg_pkg::REQ_RAW;
                [30:49]: kind = xrg_pkg::REQ_FRACTION;
                [50:69]: kind = xrg_pkg::REQ_BOUNDED;
                [70:75]: kind = xrg_pkg::REQ_RESEED;
                [76:85]: kind = xrg_pkg::REQ_LOAD;
                [86:96]: kind = xrg_pkg::REQ_READ;
                default: kind = xrg_pkg::req_t'($urandom_range(7, 6));
            endcase
            send_request(kind, pick_bound(), {$urandom, $urandom}, 2'($urandom),
                         ($urandom_range(9) == 0) ? 64'd0 : mask);
        end
        calm = 1'b0;
        stop_sending();
        sending_done = 1'b1;
    end

    // End of run: drain, settle, report.
    initial begin
        wait (sending_done);
        wait_drained();
        repeat (200) @(posedge aclk);
        if (sb.failures == 0 && sb.pending_values.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
rtl/xrg_pkg.sv
rtl/xrg_queue.sv
rtl/xrg_front.sv
rtl/xrg_back.sv
rtl/xoshiro256pp_random_generator.sv
sim/tb_top.sv
